@@ hw/rtl/ssp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the shortest path block
// no dependencies

package ssp_pkg;

  localparam int MAX_STATIONS_DEF = 128;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int DIST_BITS        = 24;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [7:0] STATION_COUNT_RESET = 8'd128;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE2,
    S_LOAD_RD,
    S_LOAD_WR,
    S_BASE_RD,
    S_BASE_CHK,
    S_RELAX_RD,
    S_RELAX_WR,
    S_FIN_RD,
    S_FIN_WAIT,
    S_OUT
  } state_t;

endpackage

@@ hw/rtl/single_source_shortest_path.sv @@
`timescale 1ns / 1ps
// shortest path engine: weight matrix ram, distance ram and control sequencer
// depends on ssp_pkg and ssp_ram

// Holds fare and time matrices in one ram (both weights per entry) and runs
// Bellman-Ford relaxation for queries. After reset, and after each clear
// transaction, a clearing pass writes every matrix entry, one per cycle, over
// 2^(2*ceil(log2(MAX_STATIONS))) entries (16384 at the default); no input is
// taken meanwhile. An edge transaction writes one entry per direction. A
// query with N active stations first loads the source row as starting
// distances, then runs relaxation passes in which each matrix entry needs
// one weight ram read and one distance ram read-modify-write; passes repeat
// until one changes nothing. Only one transaction is worked on at a time; a
// finished result sits in the output register while the next transaction is
// taken.

module single_source_shortest_path
  import ssp_pkg::*;
#(
  parameter int MAX_STATIONS = MAX_STATIONS_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_edge_a,
  input  logic [7:0]           in_edge_b,
  input  logic [15:0]          in_fare,
  input  logic [15:0]          in_travel_time,
  input  logic [7:0]           in_query_from,
  input  logic [7:0]           in_query_to,
  input  logic                 in_metric,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_BITS-1:0] out_distance,
  output logic                 out_unreachable
);

  localparam int IW  = $clog2(MAX_STATIONS);
  localparam int CW  = $clog2(MAX_STATIONS + 1);
  localparam int AW  = 2 * IW;
  localparam int WE  = WEIGHT_BITS + 1;
  localparam int WDW = 2 * WE;
  localparam int DDW = DIST_BITS + 1;
  localparam int SW  = (WEIGHT_BITS > DIST_BITS ? WEIGHT_BITS : DIST_BITS) + 1;
  localparam logic [WDW-1:0] CLR_ENTRY = {1'b1, {WEIGHT_BITS{1'b0}},
                                          1'b1, {WEIGHT_BITS{1'b0}}};

  state_t state_r, state_nxt;

  logic [7:0]             station_count_r;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0]          ea_r, ea_nxt, eb_r, eb_nxt;
  logic [WEIGHT_BITS-1:0] ef_r, ef_nxt, et_r, et_nxt;
  logic [CW-1:0]          from_r, from_nxt, to_r, to_nxt;
  logic                   metric_r, metric_nxt;
  logic [CW-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic                   changed_r, changed_nxt;
  logic [DIST_BITS-1:0]   base_r, base_nxt;
  logic [DIST_BITS-1:0]   res_dist_r, res_dist_nxt;
  logic                   res_unr_r, res_unr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DIST_BITS-1:0]   out_dist_r, out_dist_nxt;
  logic                   out_unr_r, out_unr_nxt;

  // ram ports
  logic           w_we, d_we;
  logic [AW-1:0]  w_waddr, w_raddr;
  logic [WDW-1:0] w_wdata, w_rdata;
  logic [IW-1:0]  d_waddr, d_raddr;
  logic [DDW-1:0] d_wdata, d_rdata;

  // decoded read data and derived values
  logic [CW-1:0]          cnt;
  logic                   w_nv;
  logic [WEIGHT_BITS-1:0] w_val;
  logic [SW-1:0]          sum;
  logic [DIST_BITS-1:0]   cand, load_dist;
  logic                   d_valid;
  logic [DIST_BITS-1:0]   d_dist;
  logic                   a_ok, b_ok, q_ok;
  logic                   in_acc, out_free;

  ssp_ram #(.AW(AW), .DW(WDW)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  ssp_ram #(.AW(IW), .DW(DDW)) u_dram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // effective station count and range checks
  always_comb begin
    cnt  = (32'(station_count_r) > MAX_STATIONS) ? CW'(MAX_STATIONS) : CW'(station_count_r);
    a_ok = (in_edge_a != 8'd0) && (32'(in_edge_a) <= MAX_STATIONS);
    b_ok = (in_edge_b != 8'd0) && (32'(in_edge_b) <= MAX_STATIONS);
    q_ok = (in_query_from != 8'd0) && (32'(in_query_from) <= 32'(cnt)) &&
           (in_query_to != 8'd0) && (32'(in_query_to) <= 32'(cnt));
  end

  // weight selection and saturating add
  always_comb begin
    w_nv      = metric_r ? w_rdata[WE-1] : w_rdata[WDW-1];
    w_val     = metric_r ? w_rdata[WEIGHT_BITS-1:0] : w_rdata[WE+WEIGHT_BITS-1:WE];
    load_dist = (SW'(w_val) > SW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(w_val);
    sum       = SW'(base_r) + SW'(w_val);
    cand      = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
    d_valid   = d_rdata[DDW-1];
    d_dist    = d_rdata[DIST_BITS-1:0];
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      station_count_r <= STATION_COUNT_RESET;
      changed_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      changed_r   <= changed_nxt;
      if (cfg_we) begin
        station_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    ef_r       <= ef_nxt;
    et_r       <= et_nxt;
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    metric_r   <= metric_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    res_dist_r <= res_dist_nxt;
    res_unr_r  <= res_unr_nxt;
    out_dist_r <= out_dist_nxt;
    out_unr_r  <= out_unr_nxt;
  end

  // sequencer: next state, ram control
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    ef_nxt        = ef_r;
    et_nxt        = et_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    metric_nxt    = metric_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    changed_nxt   = changed_r;
    base_nxt      = base_r;
    res_dist_nxt  = res_dist_r;
    res_unr_nxt   = res_unr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_unr_nxt   = out_unr_r;

    w_we    = 1'b0;
    w_waddr = {IW'(i_r - CW'(1)), IW'(j_r - CW'(1))};
    w_wdata = CLR_ENTRY;
    w_raddr = {IW'(i_r - CW'(1)), IW'(j_r - CW'(1))};
    d_we    = 1'b0;
    d_waddr = IW'(j_r - CW'(1));
    d_wdata = {1'b1, cand};
    d_raddr = IW'(j_r - CW'(1));

    case (state_r)
      // sweep every matrix entry to no-edge
      S_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_cnt_r;
        w_wdata = CLR_ENTRY;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      // take a transaction
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            CMD_EDGE: begin
              ea_nxt = IW'(in_edge_a - 8'd1);
              eb_nxt = IW'(in_edge_b - 8'd1);
              ef_nxt = WEIGHT_BITS'(in_fare);
              et_nxt = WEIGHT_BITS'(in_travel_time);
              if (a_ok && b_ok) begin
                w_we      = 1'b1;
                w_waddr   = {IW'(in_edge_a - 8'd1), IW'(in_edge_b - 8'd1)};
                w_wdata   = {1'b0, WEIGHT_BITS'(in_fare), 1'b0, WEIGHT_BITS'(in_travel_time)};
                state_nxt = S_EDGE2;
              end
            end
            CMD_QUERY: begin
              from_nxt   = CW'(in_query_from);
              to_nxt     = CW'(in_query_to);
              metric_nxt = in_metric;
              j_nxt      = CW'(1);
              if (q_ok) begin
                state_nxt = S_LOAD_RD;
              end else begin
                res_dist_nxt = '0;
                res_unr_nxt  = 1'b1;
                state_nxt    = S_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // mirrored edge write
      S_EDGE2: begin
        w_we      = 1'b1;
        w_waddr   = {eb_r, ea_r};
        w_wdata   = {1'b0, ef_r, 1'b0, et_r};
        state_nxt = S_IDLE;
      end

      // load source row as starting distances
      S_LOAD_RD: begin
        w_raddr   = {IW'(from_r - CW'(1)), IW'(j_r - CW'(1))};
        state_nxt = S_LOAD_WR;
      end

      S_LOAD_WR: begin
        d_we    = 1'b1;
        d_wdata = w_nv ? '0 : {1'b1, load_dist};
        if (j_r == cnt) begin
          i_nxt       = CW'(1);
          changed_nxt = 1'b0;
          state_nxt   = S_BASE_RD;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_LOAD_RD;
        end
      end

      // fetch base distance of row i, skipping the source row
      S_BASE_RD: begin
        d_raddr = IW'(i_r - CW'(1));
        if (i_r == from_r) begin
          if (i_r == cnt) begin
            i_nxt       = CW'(1);
            changed_nxt = 1'b0;
            state_nxt   = changed_r ? S_BASE_RD : S_FIN_RD;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end else begin
          state_nxt = S_BASE_CHK;
        end
      end

      S_BASE_CHK: begin
        base_nxt = d_dist;
        j_nxt    = CW'(1);
        if (d_valid) begin
          state_nxt = S_RELAX_RD;
        end else if (i_r == cnt) begin
          i_nxt       = CW'(1);
          changed_nxt = 1'b0;
          state_nxt   = changed_r ? S_BASE_RD : S_FIN_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_BASE_RD;
        end
      end

      // relax one entry: read weight and distance, then write back
      S_RELAX_RD: begin
        state_nxt = S_RELAX_WR;
      end

      S_RELAX_WR: begin
        if (!w_nv && (j_r != from_r) && (j_r != i_r) && (!d_valid || (d_dist > cand))) begin
          d_we        = 1'b1;
          changed_nxt = 1'b1;
        end
        if (j_r != cnt) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_RELAX_RD;
        end else if (i_r == cnt) begin
          i_nxt     = CW'(1);
          if (changed_r || d_we) begin
            changed_nxt = 1'b0;
            state_nxt   = S_BASE_RD;
          end else begin
            state_nxt = S_FIN_RD;
          end
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_BASE_RD;
        end
      end

      // read destination distance
      S_FIN_RD: begin
        d_raddr   = IW'(to_r - CW'(1));
        state_nxt = S_FIN_WAIT;
      end

      S_FIN_WAIT: begin
        res_dist_nxt = d_valid ? d_dist : '0;
        res_unr_nxt  = !d_valid;
        state_nxt    = S_OUT;
      end

      // hand result to the output register
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_unr_nxt   = res_unr_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_distance    = out_dist_r;
  assign out_unreachable = out_unr_r;

endmodule

@@ hw/rtl/ssp_ram.sv @@
`timescale 1ns / 1ps
// single port write, single port read synchronous ram with a registered read
// no dependencies

module ssp_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
